@@ rtl/core/binary_max_heap_priority_queue_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the heap priority queue
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define BINARY_MAX_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH

// plain property
`define HPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define HPQ_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HPQ_IMPLY_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/hpq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and codes of the heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

    localparam int KEY_W = 32;
    localparam int PAY_W = 16;
    localparam int OCC_W = 7;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_RM_ROOT,
        S_RM_LAST,
        S_RM_LOAD,
        S_DN_CHK,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_FINISH
    } state_t;

endpackage

@@ rtl/core/hpq_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_mem
// Heap entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hpq_mem #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  hpq_pkg::entry_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output hpq_pkg::entry_t rdata
);
    import hpq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/binary_max_heap_priority_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_unit
// Binary max-heap of key/payload entries kept in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | handshake             | fields
//  --------+-----------------------+------------------------------------------
//  command | cmd_valid / cmd_ready | cmd, key, payload
//  result  | rsp_valid / rsp_ready | status, out_key, out_payload, occupancy
//
// Sequencing: one command at a time. Insert fetches and compares each
// parent in turn while it climbs, and stops at the root or below a parent
// that is not smaller. Remove reads the root, then the last entry if any
// remain, and sinks it, fetching the left and then the right child at each
// level. The single RAM read port sets this: every parent or child fetch is
// issued, then compared. Full/empty rejects go straight to the result.
// Reset: heap empty, no result pending; RAM contents are not cleared.
// Stalls: a finished result sits in the output register; a new command is
// taken while it waits, and only the next result waits for rsp_ready.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_unit #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  logic                       cmd,
    input  logic [hpq_pkg::KEY_W-1:0]  key,
    input  logic [hpq_pkg::PAY_W-1:0]  payload,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output logic [1:0]                 status,
    output logic [hpq_pkg::KEY_W-1:0]  out_key,
    output logic [hpq_pkg::PAY_W-1:0]  out_payload,
    output logic [hpq_pkg::OCC_W-1:0]  occupancy
);
    import hpq_pkg::*;

    localparam int AW = $clog2(DEPTH);      // RAM address width
    localparam int CW = $clog2(DEPTH + 1);  // entry count width

    // control state
    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // working registers
    logic [AW-1:0]   at_reg, at_next;       // current hole position
    logic [AW:0]     kid_reg, kid_next;     // left child index
    entry_t          ent_reg, ent_next;     // entry being sifted
    entry_t          lft_reg, lft_next;     // left child contents
    entry_t          rem_reg, rem_next;     // removed root
    status_t         st_reg, st_next;

    // result register
    status_t              rsp_status_reg, rsp_status_next;
    entry_t               rsp_ent_reg, rsp_ent_next;
    logic [OCC_W-1:0]     rsp_occ_reg, rsp_occ_next;

    // RAM port
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    entry_t          mem_wdata, mem_rdata;

    // index arithmetic
    logic [AW:0]     left_idx, right_idx, cnt_ext;
    logic [AW-1:0]   parent_idx;
    entry_t          pick_ent;
    logic [AW-1:0]   pick_idx;

    hpq_mem #(.DEPTH(DEPTH)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign left_idx   = {at_reg, 1'b1};
    assign right_idx  = kid_reg + 1'b1;
    assign cnt_ext    = (AW+1)'(cnt_reg);
    assign parent_idx = AW'((at_reg - 1'b1) >> 1);

    // child selection: right only when strictly larger, ties go left
    always_comb
    begin
        pick_ent = mem_rdata;
        pick_idx = kid_reg[AW-1:0];
        if (state_reg == S_DN_RIGHT)
        begin
            if (mem_rdata.key > lft_reg.key)
            begin
                pick_ent = mem_rdata;
                pick_idx = right_idx[AW-1:0];
            end
            else
            begin
                pick_ent = lft_reg;
                pick_idx = kid_reg[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        at_reg         <= at_next;
        kid_reg        <= kid_next;
        ent_reg        <= ent_next;
        lft_reg        <= lft_next;
        rem_reg        <= rem_next;
        st_reg         <= st_next;
        rsp_status_reg <= rsp_status_next;
        rsp_ent_reg    <= rsp_ent_next;
        rsp_occ_reg    <= rsp_occ_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        at_next         = at_reg;
        kid_next        = kid_reg;
        ent_next        = ent_reg;
        lft_next        = lft_reg;
        rem_next        = rem_reg;
        st_next         = st_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_status_next = rsp_status_reg;
        rsp_ent_next    = rsp_ent_reg;
        rsp_occ_next    = rsp_occ_reg;
        mem_we          = 1'b0;
        mem_waddr       = at_reg;
        mem_wdata       = ent_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        cmd_ready       = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    rem_next = '0;
                    st_next  = ST_DONE;
                    if (cmd == CMD_INSERT)
                    begin
                        if (cnt_reg == CW'(DEPTH))
                        begin
                            st_next    = ST_FULL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            ent_next   = '{key: key, payload: payload};
                            at_next    = AW'(cnt_reg);
                            cnt_next   = cnt_reg + 1'b1;
                            state_next = S_UP_CHK;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            st_next    = ST_EMPTY;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg - 1'b1;
                            state_next = S_RM_ROOT;
                        end
                    end
                end
            end

            // sift up: fetch parent unless at the root
            S_UP_CHK:
            begin
                if (at_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = parent_idx;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (ent_reg.key > mem_rdata.key)
                begin
                    mem_wdata  = mem_rdata;   // parent moves down into the hole
                    at_next    = parent_idx;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_RM_ROOT:
            begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = S_RM_LAST;
            end

            S_RM_LAST:
            begin
                rem_next = mem_rdata;
                if (cnt_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(cnt_reg);
                    state_next = S_RM_LOAD;
                end
            end

            S_RM_LOAD:
            begin
                ent_next   = mem_rdata;
                at_next    = '0;
                state_next = S_DN_CHK;
            end

            // sift down: fetch left child if it exists
            S_DN_CHK:
            begin
                if (left_idx >= cnt_ext)
                begin
                    mem_we     = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = left_idx[AW-1:0];
                    kid_next   = left_idx;
                    state_next = S_DN_LEFT;
                end
            end

            S_DN_LEFT, S_DN_RIGHT:
            begin
                if (state_reg == S_DN_LEFT && right_idx < cnt_ext)
                begin
                    lft_next   = mem_rdata;
                    mem_re     = 1'b1;
                    mem_raddr  = right_idx[AW-1:0];
                    state_next = S_DN_RIGHT;
                end
                else
                begin
                    mem_we = 1'b1;
                    if (ent_reg.key >= pick_ent.key)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        mem_wdata  = pick_ent;   // child moves up into the hole
                        at_next    = pick_idx;
                        state_next = S_DN_CHK;
                    end
                end
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = st_reg;
                    rsp_ent_next    = rem_reg;
                    rsp_occ_next    = OCC_W'(cnt_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign out_key     = rsp_ent_reg.key;
    assign out_payload = rsp_ent_reg.payload;
    assign occupancy   = rsp_occ_reg;

endmodule

@@ rtl/core/hpq_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_check
// Port-level checks on the heap priority queue result channel.
// ----------------------------------------------------------------------------
`include "binary_max_heap_priority_queue_unit_macros.svh"

module hpq_check (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [1:0]                 status,
    input logic [hpq_pkg::KEY_W-1:0]  out_key,
    input logic [hpq_pkg::PAY_W-1:0]  out_payload,
    input logic [hpq_pkg::OCC_W-1:0]  occupancy
);
    import hpq_pkg::*;

    `HPQ_IMPLY_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(out_key) && $stable(occupancy), "result dropped or changed while stalled")
    `HPQ_IMPLY(a_reject_zero, rsp_valid && status != ST_DONE, out_key == '0 && out_payload == '0, "rejected command returned an entry")
    `HPQ_IMPLY(a_empty_occ, rsp_valid && status == ST_EMPTY, occupancy == '0, "empty status with entries held")

endmodule

bind binary_max_heap_priority_queue_unit hpq_check u_hpq_check (.*);

@@ verif/binary_max_heap_priority_queue_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_unit_tb
// Self-checking bench for the heap priority queue. Each accepted command is
// applied to a behavioral max-heap kept here. Responses are matched in order
// against the predicted status, removed entry and occupancy.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_unit_tb;
    import hpq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_CYCLES = 40;    // well past the slowest remove
    localparam int HOLD_CYCLES = 300;   // long response stall for the fill test

    // one predicted response
    typedef struct packed {
        status_t          st;
        logic [KEY_W-1:0] rkey;
        logic [PAY_W-1:0] rtag;
        logic [OCC_W-1:0] occ;
    } heap_result_t;

    // ------------------------------------------------------------------
    // DUT ports; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cmd_valid = 1'b0;
    logic             cmd_ready;
    logic             cmd       = CMD_INSERT;
    logic [KEY_W-1:0] key       = '0;
    logic [PAY_W-1:0] payload   = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    logic [1:0]       status;
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic [OCC_W-1:0] occupancy;

    // ------------------------------------------------------------------
    // Shadow heap: same array layout and tie rules as the block
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] heap_keys [DEPTH];
    logic [PAY_W-1:0] heap_tags [DEPTH];
    int               heap_fill = 0;

    heap_result_t     pending_results [$];   // oldest expected response first
    int               mismatch_count = 0;
    bit               idle_on        = 1'b1; // random gaps on both channels
    int               hold_off_len   = 0;    // request for a long response stall

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    binary_max_heap_priority_queue_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .key        (key),
        .payload    (payload),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .status     (status),
        .out_key    (out_key),
        .out_payload(out_payload),
        .occupancy  (occupancy)
    );

    // ------------------------------------------------------------------
    // Heap prediction
    // ------------------------------------------------------------------
    function automatic void swap_entries(input int a, input int b);
        logic [KEY_W-1:0] k;
        logic [PAY_W-1:0] t;
        k            = heap_keys[a];
        t            = heap_tags[a];
        heap_keys[a] = heap_keys[b];
        heap_tags[a] = heap_tags[b];
        heap_keys[b] = k;
        heap_tags[b] = t;
    endfunction

    function automatic heap_result_t heap_apply(input logic op,
                                                input logic [KEY_W-1:0] k,
                                                input logic [PAY_W-1:0] t);
        heap_result_t res;
        int           at;
        int           parent;
        int           left;
        int           pick;
        res.st   = ST_DONE;
        res.rkey = '0;
        res.rtag = '0;
        if (op == CMD_INSERT)
        begin
            if (heap_fill >= DEPTH)
                res.st = ST_FULL;   // rejected, heap untouched
            else
            begin
                at            = heap_fill;
                heap_keys[at] = k;
                heap_tags[at] = t;
                heap_fill++;
                // climb only past a strictly smaller parent
                while (at > 0)
                begin
                    parent = (at - 1) / 2;
                    if (heap_keys[at] <= heap_keys[parent])
                        break;
                    swap_entries(at, parent);
                    at = parent;
                end
            end
        end
        else if (heap_fill == 0)
            res.st = ST_EMPTY;
        else
        begin
            res.rkey = heap_keys[0];
            res.rtag = heap_tags[0];
            heap_fill--;
            heap_keys[0] = heap_keys[heap_fill];
            heap_tags[0] = heap_tags[heap_fill];
            // sink toward the larger child; left wins a tie, equal key stops
            at = 0;
            while (2 * at + 1 < heap_fill)
            begin
                left = 2 * at + 1;
                pick = left;
                if (left + 1 < heap_fill && heap_keys[left + 1] > heap_keys[left])
                    pick = left + 1;
                if (heap_keys[at] >= heap_keys[pick])
                    break;
                swap_entries(at, pick);
                at = pick;
            end
        end
        res.occ = heap_fill[OCC_W-1:0];
        return res;
    endfunction

    // Part of the keys come from a narrow band (0..7) or the two extremes, so equal keys meet in the heap often.
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 7))
            0, 1:    return KEY_W'($urandom_range(0, 7));
            2:       return $urandom_range(0, 1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Command side: offer one item, hold it until taken, then predict.
    // An optional idle burst comes first, with valid low.
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [KEY_W-1:0] k,
                             input logic [PAY_W-1:0] t);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= op;
        key       <= k;
        payload   <= t;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        pending_results.push_back(heap_apply(op, k, t));
    endtask

    // ------------------------------------------------------------------
    // Response side: rsp_ready is decided once per cycle here. A long
    // hold-off requested by a test is counted down in this process.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int sink_hold;
        sink_hold = 0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                rsp_ready <= 1'b0;
                sink_hold--;
            end
            else if (hold_off_len > 0)
            begin
                rsp_ready    <= 1'b0;
                sink_hold    = hold_off_len - 1;
                hold_off_len = 0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                rsp_ready <= 1'b0;
                sink_hold = $urandom_range(0, 4);
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Response checker: every accepted response pops the oldest expectation.
    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: response with none pending: status %0d key %h tag %h occ %0d",
                             $realtime, status, out_key, out_payload, occupancy);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st || out_key !== want.rkey ||
                    out_payload !== want.rtag || occupancy !== want.occ)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch exp/got status %0d/%0d key %h/%h tag %h/%h occ %0d/%0d",
                                 $realtime, want.st, status, want.rkey, out_key,
                                 want.rtag, out_payload, want.occ, occupancy);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Remove on an empty heap; key and payload must be ignored.
    task automatic test_remove_from_empty();
        send_item(CMD_REMOVE, {KEY_W{1'b1}}, {PAY_W{1'b1}});
        send_item(CMD_REMOVE, '0, '0);
    endtask

    // Extreme and alternating field patterns, then drain one past empty.
    task automatic test_field_extremes();
        send_item(CMD_INSERT, '0, '0);
        send_item(CMD_INSERT, {KEY_W{1'b1}}, {PAY_W{1'b1}});
        send_item(CMD_INSERT, 32'hAAAA_AAAA, 16'h5555);
        send_item(CMD_INSERT, 32'h5555_5555, 16'hAAAA);
        repeat (5) send_item(CMD_REMOVE, '0, '0);
    endtask

    // Equal keys must not pass each other; one larger key climbs over them.
    task automatic test_equal_keys();
        for (int i = 1; i <= 5; i++)
            send_item(CMD_INSERT, 32'h0000_1234, PAY_W'(i));
        send_item(CMD_INSERT, 32'h0000_1235, 16'h00FF);
        repeat (6) send_item(CMD_REMOVE, '0, '0);
    endtask

    // Fill to capacity while responses are held off, so the command side
    // stalls; a few inserts past full must come back rejected.
    task automatic test_fill_under_backpressure();
        hold_off_len = HOLD_CYCLES;
        while (heap_fill < DEPTH)
            send_item(CMD_INSERT, pick_key(), PAY_W'($urandom_range(0, 16'hFFFF)));
        repeat (3) send_item(CMD_INSERT, pick_key(), PAY_W'($urandom_range(0, 16'hFFFF)));
    endtask

    // Full heap drains in key order, then removes past empty.
    task automatic test_drain_past_empty();
        while (heap_fill > 0)
            send_item(CMD_REMOVE, $urandom(), PAY_W'($urandom_range(0, 16'hFFFF)));
        repeat (2) send_item(CMD_REMOVE, $urandom(), PAY_W'($urandom_range(0, 16'hFFFF)));
    endtask

    // Biased walk: grow toward full, then shrink toward empty, with the
    // odd turn in between, so every fill level and both rejects are hit.
    task automatic test_random_traffic(input int count);
        bit growing;
        int insert_odds;
        growing = 1'b1;
        repeat (count)
        begin
            if (heap_fill == DEPTH)
                growing = 1'b0;
            else if (heap_fill == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                growing = !growing;
            insert_odds = growing ? 3 : 1;
            if ($urandom_range(0, 3) < insert_odds)
                send_item(CMD_INSERT, pick_key(), PAY_W'($urandom_range(0, 16'hFFFF)));
            else
                send_item(CMD_REMOVE, $urandom(), PAY_W'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    // Back-to-back traffic on both channels, no gaps at all.
    task automatic test_steady_stream(input int count);
        idle_on = 1'b0;
        test_random_traffic(count);
    endtask

    initial
    begin : run_tests
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_remove_from_empty();
        test_field_extremes();
        test_equal_keys();
        test_fill_under_backpressure();
        test_drain_past_empty();
        test_random_traffic(850);
        test_steady_stream(100);

        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Hard stop: expected run is well under a tenth of this.
    initial
    begin : watchdog
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/hpq_pkg.sv
rtl/core/hpq_mem.sv
rtl/core/binary_max_heap_priority_queue_unit.sv
rtl/core/hpq_check.sv
verif/binary_max_heap_priority_queue_unit_tb.sv
